// File: rtl/rbd_pkg.sv
// Shared types, sizes and codes for the RGB 8x8 box downsampler.
// Used by every module of the block except rbd_ram; depends on nothing.
package rbd_pkg;

	// Tile grid geometry. BLOCK_SIZE must be a power of two.
	localparam int TILE_COLS  = 40;
	localparam int TILE_ROWS  = 28;
	localparam int BLOCK_SIZE = 8;
	localparam int BLOCK_BITS = $clog2(BLOCK_SIZE);

	// Field and datapath widths.
	localparam int DIM_W       = 10;
	localparam int CHAN_W      = 8;
	localparam int TILE_COL_W  = 6;
	localparam int TILE_ROW_W  = 5;
	localparam int TILE_ADDR_W = $clog2(TILE_COLS);
	localparam int SUM_W       = $clog2(BLOCK_SIZE * BLOCK_SIZE * 255 + 1);
	localparam int CNT_W       = $clog2(BLOCK_SIZE * BLOCK_SIZE + 1);
	localparam int SPAN_W      = $clog2(BLOCK_SIZE + 1);
	localparam int STEP_W      = $clog2(SUM_W);
	localparam int CHANNELS    = 3;

	// Covered area of the source frame, in pixels.
	localparam logic [DIM_W:0] COL_SPAN = (DIM_W + 1)'(TILE_COLS * BLOCK_SIZE);
	localparam logic [DIM_W:0] ROW_SPAN = (DIM_W + 1)'(TILE_ROWS * BLOCK_SIZE);

	// Queue between front and back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	// Configuration register map.
	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_LINE_LENGTH = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_LINE_COUNT  = 1'b1;
	localparam logic [DIM_W-1:0] LINE_LENGTH_RESET = 10'd320;
	localparam logic [DIM_W-1:0] LINE_COUNT_RESET  = 10'd224;

	// Input beat.
	typedef struct packed {
		logic              frame_start;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pixel_t;

	// Output beat.
	typedef struct packed {
		logic [TILE_COL_W-1:0] tile_column;
		logic [TILE_ROW_W-1:0] tile_row;
		logic [CHAN_W-1:0]     red_average;
		logic [CHAN_W-1:0]     green_average;
		logic [CHAN_W-1:0]     blue_average;
		logic                  frame_done;
	} tile_t;

	// Classified pixel handed from front to back.
	typedef struct packed {
		logic                   clear;
		logic                   covered;
		logic                   last;
		logic                   done;
		logic [TILE_ADDR_W-1:0] tile_col;
		logic [TILE_ROW_W-1:0]  tile_row;
		logic [CNT_W-1:0]       count;
		logic [CHAN_W-1:0]      red;
		logic [CHAN_W-1:0]      green;
		logic [CHAN_W-1:0]      blue;
	} item_t;

	// Running sums of one column tile.
	typedef struct packed {
		logic [SUM_W-1:0] r;
		logic [SUM_W-1:0] g;
		logic [SUM_W-1:0] b;
	} sum3_t;

	// Back-end sequencer states.
	typedef enum logic [1:0] {
		B_IDLE,
		B_ADD,
		B_DIV
	} back_state_t;

endpackage

// File: rtl/rgb_box_downsample_8x.sv
// Top level of the RGB 8x8 box-filter downsampler.
// Depends on rbd_pkg, rbd_front, rbd_queue and rbd_back.
//
// Usage: pixels enter in raster order on the in_valid/in_ready channel, one
// beat per pixel; frame_start marks the first pixel of a frame. Each 8x8
// block of pixels inside a 40x28 tile grid is averaged, and when the last
// covered pixel of a tile arrives one beat leaves on out_valid/out_ready
// carrying the tile coordinates and the truncated mean of red, green and blue.
// frame_done marks the last tile of a frame. Pixels outside the grid or the
// configured frame produce nothing.
// Configuration: cfg_we writes cfg_data into register cfg_index (frame width,
// frame height) at once; write only while the block is idle.
// Back end: each covered pixel takes a sum RAM read, then an add and write
// back; a tile-ending pixel then runs the fourteen divider steps and the
// output load. The back end takes no new pixel from the queue until then.
// A four-entry queue lets the front keep taking pixels while the back works.
// When the receiver stalls, the finished tile is held in the output register
// and the back end waits; the queue then fills and in_ready drops.
// Reset clears the raster position, the tile valid bits, the queue and the
// output; frame size returns to 320 by 224.
module rgb_box_downsample_8x (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rbd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rbd_pkg::DIM_W-1:0]       cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  rbd_pkg::pixel_t                 in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output rbd_pkg::tile_t                  out_data
);
	import rbd_pkg::*;

	logic [DIM_W-1:0] line_length_q, line_count_q;
	logic  push, pop, queue_full, queue_nonempty;
	item_t push_item, pop_item;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q <= LINE_LENGTH_RESET;
			line_count_q  <= LINE_COUNT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LINE_LENGTH: line_length_q <= cfg_data;
				REG_LINE_COUNT:  line_count_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	rbd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.line_length (line_length_q),
		.line_count  (line_count_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.queue_full  (queue_full),
		.push        (push),
		.item        (push_item)
	);

	rbd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_item),
		.full     (queue_full),
		.pop      (pop),
		.nonempty (queue_nonempty),
		.pop_data (pop_item)
	);

	rbd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.queue_nonempty(queue_nonempty),
		.queue_data    (pop_item),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_data      (out_data)
	);

endmodule

// File: rtl/rbd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package dependency.
module rbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/rbd_front.sv
// Front end: tracks the raster position and classifies each pixel beat.
// Depends on rbd_pkg.
module rbd_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [rbd_pkg::DIM_W-1:0]  line_length,
	input  logic [rbd_pkg::DIM_W-1:0]  line_count,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  rbd_pkg::pixel_t            in_data,
	input  logic                       queue_full,
	output logic                       push,
	output rbd_pkg::item_t             item
);
	import rbd_pkg::*;

	logic [DIM_W-1:0] pixel_column_q, pixel_row_q;
	logic [DIM_W-1:0] col, row;
	logic [DIM_W:0]   col_limit, row_limit;
	logic [DIM_W:0]   col_base, row_base, col_next, row_next;
	logic [DIM_W:0]   col_end, row_end, col_inc, row_inc;
	logic [SPAN_W-1:0] span_c, span_r;
	logic [2*SPAN_W-1:0] area;
	logic             covered, band_clear, accept;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	// Position of this pixel; a frame start forces the origin.
	always_comb begin
		col = in_data.frame_start ? '0 : pixel_column_q;
		row = in_data.frame_start ? '0 : pixel_row_q;
		col_limit = ({1'b0, line_length} < COL_SPAN) ? {1'b0, line_length} : COL_SPAN;
		row_limit = ({1'b0, line_count} < ROW_SPAN) ? {1'b0, line_count} : ROW_SPAN;
		covered = ({1'b0, col} < col_limit) && ({1'b0, row} < row_limit);
		band_clear = (col == '0) && (row[BLOCK_BITS-1:0] == '0);

		// Tile bounds, clipped to the covered area.
		col_base = {1'b0, col[DIM_W-1:BLOCK_BITS], BLOCK_BITS'(0)};
		row_base = {1'b0, row[DIM_W-1:BLOCK_BITS], BLOCK_BITS'(0)};
		col_next = col_base + (DIM_W + 1)'(BLOCK_SIZE);
		row_next = row_base + (DIM_W + 1)'(BLOCK_SIZE);
		col_end = (col_next < col_limit) ? col_next : col_limit;
		row_end = (row_next < row_limit) ? row_next : row_limit;
		col_inc = {1'b0, col} + 1'b1;
		row_inc = {1'b0, row} + 1'b1;
		span_c = SPAN_W'(col_end - col_base);
		span_r = SPAN_W'(row_end - row_base);
		area = span_c * span_r;

		item.clear    = band_clear;
		item.covered  = covered;
		item.last     = (col_inc == col_end) && (row_inc == row_end);
		item.done     = (col_inc == col_limit) && (row_inc == row_limit);
		item.tile_col = TILE_ADDR_W'(col >> BLOCK_BITS);
		item.tile_row = TILE_ROW_W'(row >> BLOCK_BITS);
		item.count    = CNT_W'(area);
		item.red      = in_data.red;
		item.green    = in_data.green;
		item.blue     = in_data.blue;
	end

	// Only pixels that touch the sums need the back end.
	assign push = accept && (covered || band_clear);

	// Raster counters advance on every accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_column_q <= '0;
			pixel_row_q    <= '0;
		end else if (accept) begin
			if (col_inc >= {1'b0, line_length}) begin
				pixel_column_q <= '0;
				if (row_inc >= {1'b0, line_count}) begin
					pixel_row_q <= '0;
				end else begin
					pixel_row_q <= row_inc[DIM_W-1:0];
				end
			end else begin
				pixel_column_q <= col_inc[DIM_W-1:0];
				pixel_row_q    <= row;
			end
		end
	end

endmodule

// File: rtl/rbd_queue.sv
// Short register queue decoupling the front end from the back end.
// Depends on rbd_pkg.
module rbd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rbd_pkg::item_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           nonempty,
	output rbd_pkg::item_t pop_data
);
	import rbd_pkg::*;

	item_t                store_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_PTR_W:0]   fill_q;

	assign full     = (fill_q == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
	assign nonempty = (fill_q != '0);
	assign pop_data = store_q[rd_ptr_q];

	// Entry storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/rbd_divider.sv
// Iterative restoring divider, one quotient bit per cycle on three lanes.
// Depends on rbd_pkg.
module rbd_divider (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	input  logic [rbd_pkg::CHANNELS-1:0][rbd_pkg::SUM_W-1:0]  dividend,
	input  logic [rbd_pkg::CNT_W-1:0]               divisor,
	output logic                                    busy,
	output logic [rbd_pkg::CHANNELS-1:0][rbd_pkg::CHAN_W-1:0] quotient
);
	import rbd_pkg::*;

	logic [CNT_W-1:0]  div_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic [CHANNELS-1:0][CNT_W-1:0] rem_q;
	logic [CHANNELS-1:0][SUM_W-1:0] quo_q;
	logic [CHANNELS-1:0][CNT_W:0]   rem_sh;
	logic [CHANNELS-1:0]            q_bit;

	assign busy = busy_q;

	// Step counter. Every dividend bit is shifted through, so a quotient wider
	// than CHAN_W bits still gives its correct low bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(SUM_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Trial subtraction for each lane.
	always_comb begin
		for (int lane = 0; lane < CHANNELS; lane++) begin
			rem_sh[lane]   = {rem_q[lane], quo_q[lane][SUM_W-1]};
			q_bit[lane]    = (rem_sh[lane] >= {1'b0, div_q});
			quotient[lane] = quo_q[lane][CHAN_W-1:0];
		end
	end

	// One shift-and-subtract per lane per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			for (int lane = 0; lane < CHANNELS; lane++) begin
				rem_q[lane] <= q_bit[lane] ? CNT_W'(rem_sh[lane] - {1'b0, div_q})
					: CNT_W'(rem_sh[lane]);
				quo_q[lane] <= {quo_q[lane][SUM_W-2:0], q_bit[lane]};
			end
		end
	end

endmodule

// File: rtl/rbd_back.sv
// Back end: accumulates tile sums in RAM, divides finished tiles, holds output.
// Depends on rbd_pkg, rbd_ram and rbd_divider.
module rbd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           queue_nonempty,
	input  rbd_pkg::item_t queue_data,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output rbd_pkg::tile_t out_data
);
	import rbd_pkg::*;

	back_state_t state_q, state_d;
	item_t       item_q;
	logic [TILE_COLS-1:0] valid_q;
	logic        out_valid_q;
	tile_t       out_q;

	logic        ram_re, ram_we, div_start, div_busy, out_load;
	sum3_t       ram_rdata, old_sum, new_sum;
	logic [CHANNELS-1:0][SUM_W-1:0]  div_dividend;
	logic [CHANNELS-1:0][CHAN_W-1:0] div_quotient;

	rbd_ram #(
		.WIDTH($bits(sum3_t)),
		.DEPTH(TILE_COLS)
	) u_sums (
		.clk  (clk),
		.we   (ram_we),
		.waddr(item_q.tile_col),
		.wdata(new_sum),
		.re   (ram_re),
		.raddr(queue_data.tile_col),
		.rdata(ram_rdata)
	);

	rbd_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (item_q.count),
		.busy    (div_busy),
		.quotient(div_quotient)
	);

	// An entry not written since the last band clear reads as zero.
	always_comb begin
		old_sum   = valid_q[item_q.tile_col] ? ram_rdata : '0;
		new_sum.r = old_sum.r + SUM_W'(item_q.red);
		new_sum.g = old_sum.g + SUM_W'(item_q.green);
		new_sum.b = old_sum.b + SUM_W'(item_q.blue);
		div_dividend = {new_sum.r, new_sum.g, new_sum.b};
	end

	// Sequencer: fetch, accumulate, then divide when a tile completes.
	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			B_IDLE: begin
				pop    = queue_nonempty;
				ram_re = queue_nonempty && queue_data.covered;
				if (ram_re) begin
					state_d = B_ADD;
				end
			end
			B_ADD: begin
				ram_we = 1'b1;
				if (item_q.last) begin
					div_start = 1'b1;
					state_d   = B_DIV;
				end else begin
					state_d = B_IDLE;
				end
			end
			B_DIV: begin
				if (!div_busy && (!out_valid_q || out_ready)) begin
					out_load = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Per-tile valid bits stand in for clearing the sum RAM.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (pop && queue_data.clear) begin
			valid_q <= '0;
		end else if (ram_we) begin
			valid_q[item_q.tile_col] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= queue_data;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.tile_column   <= TILE_COL_W'(item_q.tile_col);
			out_q.tile_row      <= item_q.tile_row;
			out_q.red_average   <= div_quotient[2];
			out_q.green_average <= div_quotient[1];
			out_q.blue_average  <= div_quotient[0];
			out_q.frame_done    <= item_q.done;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The accumulate step always follows a RAM read issued from idle.
	a_add_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_ADD |-> $past(state_q) == B_IDLE)
		else $error("accumulate without a preceding sum read");

	// A new result only appears from the divide state.
	a_out_from_div: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == B_DIV)
		else $error("result raised outside the divide state");

	// A tile just written is marked valid.
	a_written_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_ADD |=> valid_q[$past(item_q.tile_col)])
		else $error("written tile sum not marked valid");

endmodule
